/* src/tilt_pkg.sv */
`default_nettype none
package tilt_pkg;

    // Bus and field widths.
    localparam int AXIS_W  = 16;
    localparam int DIFF_W  = 17;
    localparam int SQ_W    = 35;   // Sum of two 17-bit squares.
    localparam int ROOT_W  = 18;   // Floor root of a 35-bit sum.
    localparam int ZFRAC   = 24;
    localparam int CX_W    = 46;   // CORDIC x/y datapath width.
    localparam int CZ_W    = 33;   // CORDIC angle accumulator width.
    localparam int TAB_LEN = 24;
    localparam int OUT_W   = 16;

    localparam int ANGLE_FRAC_BITS_DEF   = 8;
    localparam int CORDIC_ITERATIONS_DEF = 16;

    // Configuration register indexes.
    localparam logic [1:0] REG_BIAS_X = 2'd0;
    localparam logic [1:0] REG_BIAS_Y = 2'd1;
    localparam logic [1:0] REG_BIAS_Z = 2'd2;

    // Arctangent of 2^-i in units of 2^-24 degree.
    function automatic logic [CZ_W-1:0] atan_entry(input int i);
        logic [CZ_W-1:0] v;
        begin
            case (i)
                0:  v = 33'd754974720;
                1:  v = 33'd445687602;
                2:  v = 33'd235489088;
                3:  v = 33'd119537938;
                4:  v = 33'd60000934;
                5:  v = 33'd30029717;
                6:  v = 33'd15018523;
                7:  v = 33'd7509720;
                8:  v = 33'd3754917;
                9:  v = 33'd1877466;
                10: v = 33'd938734;
                11: v = 33'd469367;
                12: v = 33'd234684;
                13: v = 33'd117342;
                14: v = 33'd58671;
                15: v = 33'd29335;
                16: v = 33'd14668;
                17: v = 33'd7334;
                18: v = 33'd3667;
                19: v = 33'd1833;
                20: v = 33'd917;
                21: v = 33'd458;
                22: v = 33'd229;
                23: v = 33'd115;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Payload of one pipeline slot: two independent angle problems.
    typedef struct packed {
        logic signed [CX_W-1:0] px;
        logic signed [CX_W-1:0] py;
        logic signed [CZ_W-1:0] pz;
        logic                   pzero;
        logic signed [CX_W-1:0] rx;
        logic signed [CX_W-1:0] ry;
        logic signed [CZ_W-1:0] rz;
        logic                   rzero;
    } cordic_slot_t;

    // Square root slot: two remainders and partial roots plus numerators.
    typedef struct packed {
        logic [SQ_W-1:0]          prem;
        logic [ROOT_W-1:0]        proot;
        logic [SQ_W-1:0]          rrem;
        logic [ROOT_W-1:0]        rroot;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } sqrt_slot_t;

endpackage
`default_nettype wire

/* src/tilt_sqrt_cell.sv */
`default_nettype none
// One digit of the restoring square root for both angles; one stage.
module tilt_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        en,
    input  wire                        in_valid,
    input  wire tilt_pkg::sqrt_slot_t  in_slot,
    output logic                       out_valid,
    output tilt_pkg::sqrt_slot_t       out_slot
);
    localparam int BITPOS = tilt_pkg::ROOT_W - 1 - STEP;

    logic                 valid_reg;
    tilt_pkg::sqrt_slot_t slot_reg;
    tilt_pkg::sqrt_slot_t slot_next;

    // Try setting this root bit: rem >= (2*root + bit) * bit.
    function automatic logic [tilt_pkg::SQ_W+tilt_pkg::ROOT_W-1:0] step_fn(
        input logic [tilt_pkg::SQ_W-1:0] rem, input logic [tilt_pkg::ROOT_W-1:0] root);
        logic [tilt_pkg::SQ_W+1:0] trial;
        logic [tilt_pkg::SQ_W-1:0] r;
        logic [tilt_pkg::ROOT_W-1:0] q;
        begin
            trial = ((tilt_pkg::SQ_W+2)'(root) << (BITPOS + 1))
                  + ((tilt_pkg::SQ_W+2)'(1) << (2 * BITPOS));
            r = rem;
            q = root;
            if ({2'b0, rem} >= trial) begin
                r = rem - trial[tilt_pkg::SQ_W-1:0];
                q = root | (tilt_pkg::ROOT_W'(1) << BITPOS);
            end
            return {r, q};
        end
    endfunction

    always_comb begin
        slot_next = in_slot;
        {slot_next.prem, slot_next.proot} = step_fn(in_slot.prem, in_slot.proot);
        {slot_next.rrem, slot_next.rroot} = step_fn(in_slot.rrem, in_slot.rroot);
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            slot_reg <= slot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_slot  = slot_reg;
endmodule
`default_nettype wire

/* src/tilt_cordic_cell.sv */
`default_nettype none
// One vectoring rotation for both angles; one stage of the chain.
module tilt_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wire                          in_valid,
    input  wire tilt_pkg::cordic_slot_t  in_slot,
    output logic                         out_valid,
    output tilt_pkg::cordic_slot_t       out_slot
);
    localparam logic [tilt_pkg::CZ_W-1:0] ATAN = tilt_pkg::atan_entry(STEP);

    logic                   valid_reg;
    tilt_pkg::cordic_slot_t slot_reg;
    tilt_pkg::cordic_slot_t slot_next;

    always_comb begin
        slot_next = in_slot;
        if (!in_slot.py[tilt_pkg::CX_W-1]) begin
            slot_next.px = in_slot.px + (in_slot.py >>> STEP);
            slot_next.py = in_slot.py - (in_slot.px >>> STEP);
            slot_next.pz = in_slot.pz + $signed(ATAN);
        end else begin
            slot_next.px = in_slot.px - (in_slot.py >>> STEP);
            slot_next.py = in_slot.py + (in_slot.px >>> STEP);
            slot_next.pz = in_slot.pz - $signed(ATAN);
        end
        if (!in_slot.ry[tilt_pkg::CX_W-1]) begin
            slot_next.rx = in_slot.rx + (in_slot.ry >>> STEP);
            slot_next.ry = in_slot.ry - (in_slot.rx >>> STEP);
            slot_next.rz = in_slot.rz + $signed(ATAN);
        end else begin
            slot_next.rx = in_slot.rx - (in_slot.ry >>> STEP);
            slot_next.ry = in_slot.ry + (in_slot.rx >>> STEP);
            slot_next.rz = in_slot.rz - $signed(ATAN);
        end
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            slot_reg <= slot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_slot  = slot_reg;
endmodule
`default_nettype wire

/* src/accel_tilt_angles.sv */
`default_nettype none
// Accelerometer tilt: pitch = atan2(x, sqrt(y^2+z^2)) and
// roll = atan2(y, sqrt(x^2+z^2)) after per-axis bias removal, in degrees with
// ANGLE_FRAC_BITS fractional bits, clamped to +/-90 degrees. The block is a
// fully pipelined chain: a bias removal stage, a squaring stage, a summing
// stage, 18 square-root digit cells, min(CORDIC_ITERATIONS, 24) CORDIC cells
// and a rounding stage. It takes one sample per cycle unless stalled; the
// whole chain stalls only while a finished result is held and not taken. Bias
// registers are written through the configuration channel (index 0..2); other
// indexes are ignored.
module accel_tilt_angles #(
    parameter int ANGLE_FRAC_BITS   = tilt_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = tilt_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,     // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,     // pitch_angle [15:0], roll_angle [31:16]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    localparam int NIT = (CORDIC_ITERATIONS > tilt_pkg::TAB_LEN) ?
                         tilt_pkg::TAB_LEN : CORDIC_ITERATIONS;
    localparam int NSQ = tilt_pkg::ROOT_W;
    localparam int SH  = tilt_pkg::ZFRAC - ANGLE_FRAC_BITS;
    localparam int LIM = 90 * (2 ** ANGLE_FRAC_BITS);

    logic en;

    // Bias registers.
    logic signed [15:0] bias_x_reg, bias_y_reg, bias_z_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_x_reg <= '0;
            bias_y_reg <= '0;
            bias_z_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                tilt_pkg::REG_BIAS_X: bias_x_reg <= cfg_data;
                tilt_pkg::REG_BIAS_Y: bias_y_reg <= cfg_data;
                tilt_pkg::REG_BIAS_Z: bias_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage A: bias removal.
    logic v_a_reg;
    logic signed [tilt_pkg::DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v_a_reg <= 1'b0;
        else if (en) v_a_reg <= s_tvalid;
        if (en) begin
            dx_reg <= 17'($signed(s_tdata[15:0]))  - 17'(bias_x_reg);
            dy_reg <= 17'($signed(s_tdata[31:16])) - 17'(bias_y_reg);
            dz_reg <= 17'($signed(s_tdata[47:32])) - 17'(bias_z_reg);
        end
    end

    // Stage B: squares, one multiplier each.
    logic v_b_reg;
    logic [33:0] sx_reg, sy_reg, sz_reg;
    logic signed [tilt_pkg::DIFF_W-1:0] dxb_reg, dyb_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v_b_reg <= 1'b0;
        else if (en) v_b_reg <= v_a_reg;
        if (en) begin
            sx_reg  <= 34'(dx_reg * dx_reg);
            sy_reg  <= 34'(dy_reg * dy_reg);
            sz_reg  <= 34'(dz_reg * dz_reg);
            dxb_reg <= dx_reg;
            dyb_reg <= dy_reg;
        end
    end

    // Stage C: sums of squares seed the root chain.
    logic                 v_c_reg;
    tilt_pkg::sqrt_slot_t sq_c_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v_c_reg <= 1'b0;
        else if (en) v_c_reg <= v_b_reg;
        if (en) begin
            sq_c_reg.prem  <= {1'b0, sy_reg} + {1'b0, sz_reg};
            sq_c_reg.rrem  <= {1'b0, sx_reg} + {1'b0, sz_reg};
            sq_c_reg.proot <= '0;
            sq_c_reg.rroot <= '0;
            sq_c_reg.dx    <= dxb_reg;
            sq_c_reg.dy    <= dyb_reg;
        end
    end

    // Square root chain.
    logic                 sq_v [NSQ+1];
    tilt_pkg::sqrt_slot_t sq_s [NSQ+1];
    assign sq_v[0] = v_c_reg;
    assign sq_s[0] = sq_c_reg;
    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        tilt_sqrt_cell #(.STEP(g)) u_cell (
            .aclk, .aresetn, .en,
            .in_valid(sq_v[g]), .in_slot(sq_s[g]),
            .out_valid(sq_v[g+1]), .out_slot(sq_s[g+1])
        );
    end

    // CORDIC seed.
    logic                   co_v [NIT+1];
    tilt_pkg::cordic_slot_t co_s [NIT+1];
    always_comb begin
        co_v[0] = sq_v[NSQ];
        co_s[0].px = $signed({{(tilt_pkg::CX_W-tilt_pkg::ROOT_W-tilt_pkg::ZFRAC){1'b0}},
                              sq_s[NSQ].proot, {tilt_pkg::ZFRAC{1'b0}}});
        co_s[0].py = $signed({{(tilt_pkg::CX_W-tilt_pkg::DIFF_W-tilt_pkg::ZFRAC)
                              {sq_s[NSQ].dx[tilt_pkg::DIFF_W-1]}},
                              sq_s[NSQ].dx, {tilt_pkg::ZFRAC{1'b0}}});
        co_s[0].pz = '0;
        co_s[0].pzero = (sq_s[NSQ].proot == '0) && (sq_s[NSQ].dx == '0);
        co_s[0].rx = $signed({{(tilt_pkg::CX_W-tilt_pkg::ROOT_W-tilt_pkg::ZFRAC){1'b0}},
                              sq_s[NSQ].rroot, {tilt_pkg::ZFRAC{1'b0}}});
        co_s[0].ry = $signed({{(tilt_pkg::CX_W-tilt_pkg::DIFF_W-tilt_pkg::ZFRAC)
                              {sq_s[NSQ].dy[tilt_pkg::DIFF_W-1]}},
                              sq_s[NSQ].dy, {tilt_pkg::ZFRAC{1'b0}}});
        co_s[0].rz = '0;
        co_s[0].rzero = (sq_s[NSQ].rroot == '0) && (sq_s[NSQ].dy == '0);
    end
    for (genvar g = 0; g < NIT; g++) begin : g_cordic
        tilt_cordic_cell #(.STEP(g)) u_cell (
            .aclk, .aresetn, .en,
            .in_valid(co_v[g]), .in_slot(co_s[g]),
            .out_valid(co_v[g+1]), .out_slot(co_s[g+1])
        );
    end

    // Rounding and clamping of one angle.
    function automatic logic [15:0] finish(input logic signed [tilt_pkg::CZ_W-1:0] z,
                                           input logic zero);
        logic signed [tilt_pkg::CZ_W-1:0] r;
        logic signed [tilt_pkg::CZ_W-1:0] lim;
        begin
            lim = tilt_pkg::CZ_W'(LIM);
            r = (z + $signed(tilt_pkg::CZ_W'(1) << (SH - 1))) >>> SH;
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
            if (zero) r = '0;
            return r[15:0];
        end
    endfunction

    // Output register; the chain advances unless it holds an untaken result.
    logic        out_v_reg;
    logic [31:0] out_d_reg;
    assign en = !out_v_reg || m_tready;
    assign s_tready = en;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (en) out_v_reg <= co_v[NIT];
        if (en) begin
            out_d_reg <= {finish(co_s[NIT].rz, co_s[NIT].rzero),
                          finish(co_s[NIT].pz, co_s[NIT].pzero)};
        end
    end
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
endmodule
`default_nettype wire

/* bench/accel_tilt_angles_tb.sv */
`timescale 1ns / 1ps
module accel_tilt_angles_tb;

    localparam int FRAC = tilt_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int ITERS = (tilt_pkg::CORDIC_ITERATIONS_DEF > tilt_pkg::TAB_LEN) ?
                           tilt_pkg::TAB_LEN : tilt_pkg::CORDIC_ITERATIONS_DEF;
    localparam int LATENCY = 22 + ITERS;
    // An unused register index; writes to it must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } tilt_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Testbench copy of the bias registers.
    logic signed [15:0] bias_x_q, bias_y_q, bias_z_q;
    tilt_t angles_pending[$];
    int    errors = 0;
    int    samples_sent = 0;
    int    angles_checked = 0;
    bit    idle_enable = 1'b1;

    accel_tilt_angles i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    // Exact integer floor square root.
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC angle of (root, num) in degrees, rounded and clamped.
    function automatic logic [15:0] tilt_angle(longint num, longint a, longint b);
        longint root, x, y, z, xs, ys, r, lim;
        longint tab[24];
        tab = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                15018523, 7509720, 3754917, 1877466, 938734, 469367,
                234684, 117342, 58671, 29335, 14668, 7334,
                3667, 1833, 917, 458, 229, 115};
        root = longint'(floor_sqrt(longint'(a * a + b * b)));
        if (num == 0 && root == 0) return 16'd0;
        x = root <<< tilt_pkg::ZFRAC;
        y = num <<< tilt_pkg::ZFRAC;
        z = 0;
        for (int i = 0; i < ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += tab[i];
            end else begin
                x -= ys; y += xs; z -= tab[i];
            end
        end
        r = (z + (64'sd1 <<< (tilt_pkg::ZFRAC - FRAC - 1))) >>> (tilt_pkg::ZFRAC - FRAC);
        lim = 64'sd90 <<< FRAC;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[15:0];
    endfunction

    function automatic tilt_t predict_tilt(logic signed [15:0] ax, logic signed [15:0] ay,
                                           logic signed [15:0] az);
        tilt_t t;
        longint dx, dy, dz;
        dx = longint'(ax) - longint'(bias_x_q);
        dy = longint'(ay) - longint'(bias_y_q);
        dz = longint'(az) - longint'(bias_z_q);
        t.pitch = tilt_angle(dx, dy, dz);
        t.roll = tilt_angle(dy, dx, dz);
        return t;
    endfunction

    // Drops valid for a random idle burst now and then.
    task automatic random_gap();
        int n;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Sends one sample and records its expected angles.
    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        random_gap();
        angles_pending.push_back(predict_tilt(ax, ay, az));
        s_tvalid <= 1'b1;
        s_tdata <= {az, ay, ax};
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (angles_pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            tilt_pkg::REG_BIAS_X: bias_x_q = val;
            tilt_pkg::REG_BIAS_Y: bias_y_q = val;
            tilt_pkg::REG_BIAS_Z: bias_z_q = val;
            default: ;
        endcase
    endtask

    task automatic set_bias(logic [15:0] bx, logic [15:0] by, logic [15:0] bz);
        wait_drained();
        write_reg(tilt_pkg::REG_BIAS_X, bx);
        write_reg(tilt_pkg::REG_BIAS_Y, by);
        write_reg(tilt_pkg::REG_BIAS_Z, bz);
    endtask

    // Result receiver with random stalls.
    always @(posedge aclk) begin
        if (!aresetn || !idle_enable) begin
            m_tready <= aresetn;
        end else if (!m_tready) begin
            m_tready <= ($urandom_range(0, 2) == 0);
        end else begin
            m_tready <= ($urandom_range(0, 7) != 0);
        end
    end

    // Compares every accepted result with the oldest expectation.
    always @(posedge aclk) begin
        tilt_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (angles_pending.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end else begin
                e = angles_pending.pop_front();
                angles_checked++;
                if (m_tdata[15:0] !== e.pitch) begin
                    $error("pitch_angle expected %0d actual %0d", e.pitch,
                           $signed(m_tdata[15:0]));
                    errors++;
                end
                if (m_tdata[31:16] !== e.roll) begin
                    $error("roll_angle expected %0d actual %0d", e.roll,
                           $signed(m_tdata[31:16]));
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [15:0] ext[5];
        ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        send_sample(16'd0, 16'd0, 16'd0);       // all zero: both angles zero
        send_sample(16'd1000, 16'd0, 16'd0);    // root zero, positive numerator
        send_sample(16'hFC18, 16'd0, 16'd0);    // root zero, negative numerator
        send_sample(16'd0, 16'h8000, 16'd0);
        send_sample(16'd0, 16'd0, 16'h7FFF);
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 4; j++)
                send_sample(ext[i], ext[j], ext[(i + j) % 5]);
    endtask

    task automatic test_bias_extremes();
        set_bias(16'h7FFF, 16'h8000, 16'h7FFF);
        send_sample(16'h8000, 16'h7FFF, 16'h8000);  // widest differences
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF);  // zero after bias
        send_sample(16'h8000, 16'h8000, 16'h7FFF);
        wait_drained();
        write_reg(REG_UNUSED, 16'h1234);            // must be ignored
        send_sample(16'h0000, 16'h0000, 16'h0000);
        set_bias(16'h8000, 16'h7FFF, 16'h8000);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
        send_sample(16'h8000, 16'h7FFF, 16'h8000);
    endtask

    task automatic test_random(int count);
        logic [15:0] v[3];
        for (int i = 0; i < count; i++) begin
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(0, 5))
                    0: v[k] = 16'($urandom_range(0, 15)) - 16'd8;
                    1: v[k] = $urandom_range(0, 1) ?
                              16'h7FFF - 16'($urandom_range(0, 3)) :
                              16'h8000 + 16'($urandom_range(0, 3));
                    default: v[k] = 16'($urandom);
                endcase
            end
            send_sample(v[0], v[1], v[2]);
        end
    endtask

    initial begin
        bias_x_q = 0;
        bias_y_q = 0;
        bias_z_q = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_bias_extremes();
        set_bias(16'($urandom), 16'($urandom), 16'($urandom));
        test_random(600);
        set_bias(16'h0000, 16'h0000, 16'h0000);
        test_random(600);
        set_bias(16'($urandom), 16'($urandom), 16'($urandom));
        test_random(300);
        // Full-rate tail with no idling on either side.
        idle_enable = 1'b0;
        test_random(300);
        wait_drained();
        $display("Sent %0d samples through several bias settings; %0d angle pairs checked.",
                 samples_sent, angles_checked);
        if (errors == 0 && angles_pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

/* accel_tilt_angles.f */
src/tilt_pkg.sv
src/tilt_sqrt_cell.sv
src/tilt_cordic_cell.sv
src/accel_tilt_angles.sv
bench/accel_tilt_angles_tb.sv
